FILE: sv/todat_pkg.sv
// Shared constants, codes and types for the time-of-day alarm table.
package todat_pkg;

  localparam int TABLE_SIZE  = 8;
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);

  localparam int OP_W        = 3;
  localparam int IDX_FLD_W   = 3;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int SEC_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int COUNT_FLD_W = 4;
  localparam int MASK_W      = 8;
  localparam int TOD_W       = 17;

  // Width wide enough to compare an index field against the entry count.
  localparam int CMP_W       = (CNT_W > IDX_FLD_W) ? CNT_W : IDX_FLD_W;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;

  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic              occ;
    logic              rep;
    logic              en;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } entry_t;

  typedef struct packed {
    logic              upd;
    logic [OP_W-1:0]   op;
    logic [CMP_W-1:0]  idx;
    logic [CMP_W-1:0]  count;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              rep;
    logic              en;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [CMP_W-1:0]  idx;
    logic [TOD_W-1:0]  tod;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: sv/time_of_day_alarm_table.sv
// Top level of the time-of-day alarm table: control, status and result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  in_      | input     | in_tvalid/tready   | command: operation, index, time, flags
//  out_     | output    | out_tvalid/tready  | status, count, fired mask, next alarm
//
// After its transfer a command passes the update step, which writes all cells, the scan
// step, which ripples the earliest-alarm token through the row of cells, and the done step,
// which loads the result register; the next command is taken only in the idle step, once
// the current one is through. Synchronous active-low reset clears the table.
// A new command is taken while a result still waits in the output register;
// the block then holds in the final step until the output side frees up.
module time_of_day_alarm_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] operation, [5:3] index, [10:6] hour, [16:11] minute, [22:17] second,
  // [23] repeat_flag, [24] enable_flag, [31:25] zero
  input  logic [todat_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [5:2] alarm_count, [13:6] fired_mask, [14] next_valid,
  // [17:15] next_index, [22:18] next_hour, [28:23] next_minute,
  // [34:29] next_second, [39:35] zero
  output logic [todat_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int N      = todat_pkg::TABLE_SIZE;
  localparam int SCAN_W = $clog2(N + 1);

  todat_pkg::state_t state_r, state_nxt;

  // latched command
  logic [todat_pkg::OP_W-1:0]      op_r;
  logic [todat_pkg::IDX_FLD_W-1:0] idx_r;
  logic [todat_pkg::HOUR_W-1:0]    hour_r;
  logic [todat_pkg::MIN_W-1:0]     minute_r;
  logic [todat_pkg::SEC_W-1:0]     second_r;
  logic                            rep_r;
  logic                            en_r;

  logic [todat_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [todat_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [todat_pkg::MASK_W-1:0]    fired_r, fired_nxt;
  logic [SCAN_W-1:0]               scan_cnt_r, scan_cnt_nxt;

  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [todat_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                            accept;
  logic                            do_update;
  logic                            load_out;
  logic                            idx_bad;
  logic [todat_pkg::CMP_W-1:0]     idx_ext;
  logic [todat_pkg::CMP_W-1:0]     count_ext;

  todat_pkg::cmd_t   cmd;
  todat_pkg::entry_t entry_w [N];
  todat_pkg::tok_t   tok_w   [N];
  logic [N-1:0]      match_w;
  todat_pkg::tok_t   best;

  assign accept    = in_tvalid && in_tready;
  assign idx_ext   = todat_pkg::CMP_W'(idx_r);
  assign count_ext = todat_pkg::CMP_W'(count_r);
  assign idx_bad   = (idx_ext >= count_ext);

  // Broadcast the latched command to every cell.
  always_comb begin
    cmd        = '0;
    cmd.upd    = do_update;
    cmd.op     = op_r;
    cmd.idx    = idx_ext;
    cmd.count  = count_ext;
    cmd.hour   = hour_r;
    cmd.minute = minute_r;
    cmd.second = second_r;
    cmd.rep    = rep_r;
    cmd.en     = en_r;
  end

  // Row of cells: each passes its entry down for delete and its token up the row.
  for (genvar i = 0; i < N; i++) begin : g_cell
    todat_pkg::entry_t nbr;
    todat_pkg::tok_t   tin;
    if (i == N - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end
    if (i == 0) begin : g_first
      assign tin = '0;
    end else begin : g_rest
      assign tin = tok_w[i-1];
    end
    todat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (todat_pkg::CMP_W'(i)),
      .cmd       (cmd),
      .nbr_entry (nbr),
      .tok_in    (tin),
      .entry     (entry_w[i]),
      .match     (match_w[i]),
      .tok_out   (tok_w[i])
    );
  end

  // Fired mask carries entries below the mask width only.
  for (genvar j = 0; j < todat_pkg::MASK_W; j++) begin : g_fire
    if (j < N) begin : g_in
      assign fired_nxt[j] = match_w[j];
    end else begin : g_out
      assign fired_nxt[j] = 1'b0;
    end
  end

  // Status and count after this command.
  always_comb begin
    status_nxt = todat_pkg::STAT_OK;
    count_nxt  = count_r;
    case (op_r)
      todat_pkg::OP_ADD: begin
        if (count_r >= todat_pkg::CNT_W'(N)) begin
          status_nxt = todat_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      todat_pkg::OP_DELETE: begin
        if (idx_bad) begin
          status_nxt = todat_pkg::STAT_BAD_INDEX;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      todat_pkg::OP_ENABLE,
      todat_pkg::OP_DISABLE: begin
        if (idx_bad) begin
          status_nxt = todat_pkg::STAT_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      todat_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = todat_pkg::S_UPDATE;
        end
      end
      todat_pkg::S_UPDATE: begin
        state_nxt = todat_pkg::S_SCAN;
      end
      todat_pkg::S_SCAN: begin
        if (scan_cnt_r == SCAN_W'(N - 1)) begin
          state_nxt = todat_pkg::S_DONE;
        end
      end
      todat_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = todat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = todat_pkg::S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_tready    = 1'b0;
    do_update    = 1'b0;
    load_out     = 1'b0;
    scan_cnt_nxt = '0;
    case (state_r)
      todat_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      todat_pkg::S_UPDATE: begin
        do_update = 1'b1;
      end
      todat_pkg::S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
      todat_pkg::S_DONE: begin
        load_out = !out_tvalid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // Hold the result until the downstream transfer; drop valid once taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  assign best = tok_w[N-1];

  // Pack the result word; the next-alarm fields stay zero when nothing is enabled.
  always_comb begin
    out_tdata_nxt        = '0;
    out_tdata_nxt[1:0]   = status_r;
    out_tdata_nxt[5:2]   = todat_pkg::COUNT_FLD_W'(count_r);
    out_tdata_nxt[13:6]  = fired_r;
    out_tdata_nxt[14]    = best.valid;
    out_tdata_nxt[17:15] = best.valid ? todat_pkg::IDX_FLD_W'(best.idx) : '0;
    out_tdata_nxt[22:18] = best.valid ? best.hour : '0;
    out_tdata_nxt[28:23] = best.valid ? best.minute : '0;
    out_tdata_nxt[34:29] = best.valid ? best.second : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= todat_pkg::S_IDLE;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (do_update) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tdata[2:0];
      idx_r    <= in_tdata[5:3];
      hour_r   <= in_tdata[10:6];
      minute_r <= in_tdata[16:11];
      second_r <= in_tdata[22:17];
      rep_r    <= in_tdata[23];
      en_r     <= in_tdata[24];
    end
    if (do_update) begin
      status_r <= status_nxt;
      fired_r  <= fired_nxt;
    end
    if (load_out) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: sv/todat_cell.sv
// One table slot: holds an alarm entry and forwards the running earliest-alarm token.
module todat_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [todat_pkg::CMP_W-1:0] cell_idx,
  input  todat_pkg::cmd_t             cmd,
  input  todat_pkg::entry_t           nbr_entry,
  input  todat_pkg::tok_t             tok_in,
  output todat_pkg::entry_t           entry,
  output logic                        match,
  output todat_pkg::tok_t             tok_out
);

  todat_pkg::entry_t entry_r, entry_nxt;
  todat_pkg::tok_t   tok_r, tok_nxt;
  logic              idx_ok;
  logic              mine;
  logic [todat_pkg::TOD_W-1:0] tod;

  assign idx_ok = (cmd.idx < cmd.count);
  assign match  = entry_r.occ && entry_r.en && (cmd.op == todat_pkg::OP_CHECK) &&
                  (entry_r.hour == cmd.hour) && (entry_r.minute == cmd.minute) &&
                  (entry_r.second == cmd.second);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.upd) begin
      case (cmd.op)
        todat_pkg::OP_ADD: begin
          if ((cmd.count < todat_pkg::CMP_W'(todat_pkg::TABLE_SIZE)) &&
              (cell_idx == cmd.count)) begin
            entry_nxt.occ    = 1'b1;
            entry_nxt.rep    = cmd.rep;
            entry_nxt.en     = cmd.en;
            entry_nxt.hour   = cmd.hour;
            entry_nxt.minute = cmd.minute;
            entry_nxt.second = cmd.second;
          end
        end
        todat_pkg::OP_DELETE: begin
          // take the neighbor's entry at and above the removed slot
          if (idx_ok && (cell_idx >= cmd.idx)) begin
            entry_nxt = nbr_entry;
          end
        end
        todat_pkg::OP_ENABLE: begin
          if (idx_ok && (cell_idx == cmd.idx)) begin
            entry_nxt.en = 1'b1;
          end
        end
        todat_pkg::OP_DISABLE: begin
          if (idx_ok && (cell_idx == cmd.idx)) begin
            entry_nxt.en = 1'b0;
          end
        end
        todat_pkg::OP_CHECK: begin
          // one-shot alarms drop their enable once they fire
          if (match && !entry_r.rep) begin
            entry_nxt.en = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tod = todat_pkg::TOD_W'(entry_r.hour) * todat_pkg::TOD_W'(todat_pkg::SECS_PER_HOUR) +
               todat_pkg::TOD_W'(entry_r.minute) * todat_pkg::TOD_W'(todat_pkg::SECS_PER_MIN) +
               todat_pkg::TOD_W'(entry_r.second);

  assign mine = entry_r.occ && entry_r.en;

  // Strictly earlier replaces the token, so ties keep the lower index.
  always_comb begin
    tok_nxt = tok_in;
    if (mine && (!tok_in.valid || (tod < tok_in.tod))) begin
      tok_nxt.valid  = 1'b1;
      tok_nxt.idx    = cell_idx;
      tok_nxt.tod    = tod;
      tok_nxt.hour   = entry_r.hour;
      tok_nxt.minute = entry_r.minute;
      tok_nxt.second = entry_r.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign entry   = entry_r;
  assign tok_out = tok_r;

endmodule
